[design/sorted_priority_queue_macros.svh]
// Assertion helpers for the queue RTL. Both expect a clock named clk
// and an active-high reset named rst in scope.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Condition that must hold at every edge outside reset
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked at every edge outside reset
`define SPQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[design/spq_pkg.sv]
package spq_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int DATA_W              = 32;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } spq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  // Contents of one cell of the row
  typedef struct packed {
    logic                     occ;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } spq_entry_t;

  // Pair travelling rightwards along the row. shift: a displaced entry that
  // drops into the next cell unconditionally.
  typedef struct packed {
    logic                     valid;
    logic                     shift;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } spq_token_t;

endpackage

[design/spq_channels.sv]
// Request channel: one operation per beat
interface spq_req_if;
  import spq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic signed [DATA_W-1:0] item_value;
  logic signed [DATA_W-1:0] item_priority;
  modport source (output valid, output operation, output item_value,
                  output item_priority, input ready);
  modport sink   (input valid, input operation, input item_value,
                  input item_priority, output ready);
endinterface

// Response channel: one result per request
interface spq_rsp_if;
  import spq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] head_value;
  logic signed [DATA_W-1:0] head_priority;
  logic [1:0]               status;
  logic                     is_empty;
  modport source (output valid, output head_value, output head_priority,
                  output status, output is_empty, input ready);
  modport sink   (input valid, input head_value, input head_priority,
                  input status, input is_empty, output ready);
endinterface

// Mode register write channel
interface spq_cfg_if;
  logic valid;
  logic ready;
  logic order_mode;
  modport source (output valid, output order_mode, input ready);
  modport sink   (input valid, input order_mode, output ready);
endinterface

[design/spq_cell.sv]
module spq_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                order_mode,
  input  logic                pop,
  input  spq_pkg::spq_token_t tok_in,
  input  spq_pkg::spq_entry_t right,
  output spq_pkg::spq_entry_t ent,
  output spq_pkg::spq_token_t tok_out
);
  import spq_pkg::*;

  logic                     occ, occ_next;
  logic signed [DATA_W-1:0] value, value_next;
  logic signed [DATA_W-1:0] prio, prio_next;
  spq_token_t               tok, tok_next;
  logic                     rel_ok;

  // Ordering relation between the stored priority and the arriving one
  always_comb begin
    if (order_mode) begin
      rel_ok = prio >= tok_in.prio;
    end else begin
      rel_ok = prio <= tok_in.prio;
    end
  end

  // Pop shifts left; an arriving pair either settles here or moves on
  always_comb begin
    occ_next   = occ;
    value_next = value;
    prio_next  = prio;
    tok_next   = '0;
    if (pop) begin
      occ_next   = right.occ;
      value_next = right.value;
      prio_next  = right.prio;
    end else if (tok_in.valid) begin
      if (!occ) begin
        occ_next   = 1'b1;
        value_next = tok_in.value;
        prio_next  = tok_in.prio;
      end else if (tok_in.shift || !rel_ok) begin
        value_next     = tok_in.value;
        prio_next      = tok_in.prio;
        tok_next.valid = 1'b1;
        tok_next.shift = 1'b1;
        tok_next.value = value;
        tok_next.prio  = prio;
      end else begin
        tok_next       = tok_in;
        tok_next.shift = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= 1'b0;
      tok.valid <= 1'b0;
    end else begin
      occ       <= occ_next;
      tok.valid <= tok_next.valid;
    end
    value     <= value_next;
    prio      <= prio_next;
    tok.shift <= tok_next.shift;
    tok.value <= tok_next.value;
    tok.prio  <= tok_next.prio;
  end

  always_comb begin
    ent.occ   = occ;
    ent.value = value;
    ent.prio  = prio;
    tok_out   = tok;
  end

endmodule

[design/sorted_priority_queue.sv]
// Sorted priority queue built as a row of QUEUE_DEPTH cells, head in cell 0.
// On pop and peek the head is read from cell 0 and, on pop, every cell takes
// its right neighbour's contents in the same cycle. A push is accepted in its
// request beat and then travels rightwards one cell per cycle until it lands;
// a travel counter, loaded with the entry count at the push beat, must run
// down before the next request is taken. Each result sits in an output
// register from the cycle after its request beat; a new request is taken only
// while that register is empty or in the cycle its result beat leaves. The mode
// register chooses the head as smallest (0) or largest (1) priority; equal
// priorities leave in arrival order. Pushes into a full queue are dropped with
// status full; pop or peek on an empty queue returns status empty and zeros.
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp,
  spq_cfg_if.sink   cfg
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic              order_mode;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     busy_cnt, busy_cnt_next;
  logic              req_fire, full, empty;
  logic              push_go, pop_go, read_go;
  spq_token_t        tok [QUEUE_DEPTH+1];
  spq_entry_t        ent [QUEUE_DEPTH+1];

  // Mode register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      order_mode <= cfg.order_mode;
    end
  end

  // Request decode
  assign req.ready = (busy_cnt == '0) && (!rsp.valid || rsp.ready);
  assign req_fire  = req.valid && req.ready;
  assign full      = count == CW'(QUEUE_DEPTH);
  assign empty     = count == '0;
  assign push_go   = req_fire && (req.operation == OP_PUSH) && !full;
  assign pop_go    = req_fire && (req.operation == OP_POP) && !empty;
  assign read_go   = req_fire && !empty
                     && ((req.operation == OP_POP) || (req.operation == OP_PEEK));

  // Occupancy and push travel counter
  always_comb begin
    count_next    = count;
    busy_cnt_next = busy_cnt;
    if (push_go) begin
      count_next    = count + 1'b1;
      busy_cnt_next = count;
    end else begin
      if (pop_go) begin
        count_next = count - 1'b1;
      end
      if (busy_cnt != '0) begin
        busy_cnt_next = busy_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      busy_cnt <= '0;
    end else begin
      count    <= count_next;
      busy_cnt <= busy_cnt_next;
    end
  end

  // New pair enters cell 0
  always_comb begin
    tok[0].valid = push_go;
    tok[0].shift = 1'b0;
    tok[0].value = req.item_value;
    tok[0].prio  = req.item_priority;
  end

  assign ent[QUEUE_DEPTH] = '0;

  // Row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .order_mode (order_mode),
      .pop        (pop_go),
      .tok_in     (tok[i]),
      .right      (ent[i+1]),
      .ent        (ent[i]),
      .tok_out    (tok[i+1])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (req_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (req_fire) begin
      rsp.head_value    <= read_go ? ent[0].value : '0;
      rsp.head_priority <= read_go ? ent[0].prio : '0;
      rsp.is_empty      <= count_next == '0;
      if ((req.operation == OP_PUSH) && full) begin
        rsp.status <= ST_FULL;
      end else if (((req.operation == OP_POP) || (req.operation == OP_PEEK)) && empty) begin
        rsp.status <= ST_EMPTY;
      end else begin
        rsp.status <= ST_OK;
      end
    end
  end

  // Checks
  `SPQ_ASSERT_ALWAYS(a_no_spill, !tok[QUEUE_DEPTH].valid, "pair ran off the end of the row")
  `SPQ_ASSERT_ALWAYS(a_head_occ, (count != '0) == ent[0].occ, "head cell disagrees with count")
  `SPQ_ASSERT_IMPLY(a_tail_occ, busy_cnt == '0, ent[QUEUE_DEPTH-1].occ == full, "bad tail cell")

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import spq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEFAULT;
  // Operation code outside the defined set; the block treats it as a no-op
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 330;
  // Ordering used per phase, bit n for phase n (0: smallest first, 1: largest first)
  localparam logic [PHASES-1:0] MODE_PLAN = 5'b10110;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = DEPTH + 8;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } queue_op_t;

  typedef struct {
    logic [1:0]               operation;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
    logic [1:0]               status;
    logic                     is_empty;
  } head_result_t;

  logic clk = 1'b0;
  logic rst;

  spq_req_if req ();
  spq_rsp_if rsp ();
  spq_cfg_if cfg ();

  sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always #1 clk = ~clk;

  // Shadow copy of the sorted store, head at index 0
  logic signed [DATA_W-1:0] shadow_value[$];
  logic signed [DATA_W-1:0] shadow_prio[$];
  logic                     largest_first = 1'b0;

  queue_op_t    op_backlog[$];
  head_result_t expected_heads[$];

  int n_queued = 0, n_meaningful = 0, n_taken = 0, n_checked = 0, n_errors = 0;
  int n_push_ok = 0, n_full = 0, n_empty = 0, n_pop_ok = 0, n_peek_ok = 0;
  int n_mode_writes = 0;
  int gen_fill = 0;
  int idle_cycles = 0;

  bit req_beat = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0, stall_left = 0, send_gap = 0;
  int send_calm = 0, recv_calm = 0;

  // Expected outcome of one operation; updates the shadow store
  function automatic head_result_t apply_queue_op(queue_op_t op);
    head_result_t r;
    int pos;
    int i;
    logic holds;
    r.operation = op.operation;
    r.value = '0;
    r.prio = '0;
    r.status = ST_OK;
    case (op.operation)
      OP_PUSH: begin
        if (shadow_prio.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = shadow_prio.size();
          for (i = 0; i < shadow_prio.size(); i++) begin
            holds = largest_first ? (shadow_prio[i] >= op.prio) : (shadow_prio[i] <= op.prio);
            if (!holds) begin
              pos = i;
              break;
            end
          end
          shadow_value.insert(pos, op.value);
          shadow_prio.insert(pos, op.prio);
        end
      end
      OP_POP, OP_PEEK: begin
        if (shadow_prio.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = shadow_value[0];
          r.prio = shadow_prio[0];
          if (op.operation == OP_POP) begin
            void'(shadow_value.pop_front());
            void'(shadow_prio.pop_front());
          end
        end
      end
      default: ;
    endcase
    r.is_empty = (shadow_prio.size() == 0);
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh8000_0001;
      3: return 32'sh7fff_fffe;
      4: return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  // Small ranges give plenty of equal priorities
  function automatic logic signed [DATA_W-1:0] pick_prio();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return $signed($urandom_range(0, 8)) - 4;
    else if (k < 70) return $urandom;
    else if (k < 85) return pick_extreme();
    else return $signed($urandom_range(0, 2000)) - 1000;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 4) == 0) return pick_extreme();
    return $urandom;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int random_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    else if (k < 85) return $urandom_range(1, 3);
    else if (k < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Occupancy at generation time is exact: it does not depend on timing
  task automatic add_op(logic [1:0] code, logic signed [DATA_W-1:0] v,
                        logic signed [DATA_W-1:0] p);
    queue_op_t op;
    op.operation = code;
    op.value = v;
    op.prio = p;
    op_backlog.push_back(op);
    n_queued++;
    if (code != OP_NOP) n_meaningful++;
    if (code == OP_PUSH && gen_fill < DEPTH) gen_fill++;
    if (code == OP_POP && gen_fill > 0) gen_fill--;
  endtask

  task automatic random_run(int len);
    int k;
    repeat (len) begin
      k = $urandom_range(0, 99);
      if (k < 45) add_op(OP_PUSH, pick_value(), pick_prio());
      else if (k < 78) add_op(OP_POP, $urandom, $urandom);
      else if (k < 96) add_op(OP_PEEK, $urandom, $urandom);
      else add_op(OP_NOP, $urandom, $urandom);
    end
  endtask

  // Fill past full, then drain past empty
  task automatic fill_then_drain();
    int n;
    n = DEPTH - gen_fill + $urandom_range(1, 3);
    repeat (n) add_op(OP_PUSH, pick_value(), pick_prio());
    n = gen_fill + $urandom_range(1, 2);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) add_op(OP_PEEK, $urandom, $urandom);
      add_op(OP_POP, $urandom, $urandom);
    end
  endtask

  // Runs of equal priority to check arrival order among ties
  task automatic tie_burst();
    logic signed [DATA_W-1:0] p;
    p = ($urandom_range(0, 1) == 0) ? pick_extreme() : pick_prio();
    repeat ($urandom_range(3, 8)) begin
      if ($urandom_range(0, 3) == 0) add_op(OP_PUSH, pick_value(), pick_prio());
      else add_op(OP_PUSH, pick_value(), p);
    end
    repeat ($urandom_range(2, 8)) add_op(OP_POP, $urandom, $urandom);
  endtask

  task automatic directed_ops();
    add_op(OP_POP, 32'sh1234_5678, 32'sh0000_0001);
    add_op(OP_PEEK, 32'sh0, 32'sh0);
    add_op(OP_NOP, 32'sh5a5a_5a5a, -32'sd1);
    add_op(OP_PUSH, 32'sh7fff_ffff, 32'sh0);
    add_op(OP_PUSH, 32'sh8000_0000, 32'sh7fff_ffff);
    add_op(OP_PUSH, 32'sh0, 32'sh8000_0000);
    add_op(OP_PUSH, 32'sh1, 32'sh0);
    add_op(OP_PUSH, -32'sd1, -32'sd1);
    add_op(OP_PUSH, 32'sh2, 32'sh8000_0000);
    add_op(OP_PEEK, $urandom, $urandom);
    add_op(OP_NOP, 32'sh8000_0000, 32'sh7fff_ffff);
    repeat (6) add_op(OP_POP, $urandom, $urandom);
    add_op(OP_POP, -32'sd1, -32'sd1);
    add_op(OP_PEEK, 32'sh7fff_ffff, 32'sh8000_0000);
  endtask

  task automatic write_order_mode(logic m);
    @(negedge clk);
    cfg.order_mode <= m;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Wait until every beat is through and the row has settled
  task automatic wait_quiet();
    while (n_taken != n_queued || expected_heads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_head(head_result_t want, head_result_t got);
    if (got.value !== want.value) begin
      $display("%0t: head_value mismatch, expected %0d, actual %0d", $realtime,
               want.value, got.value);
      n_errors++;
    end
    if (got.prio !== want.prio) begin
      $display("%0t: head_priority mismatch, expected %0d, actual %0d", $realtime,
               want.prio, got.prio);
      n_errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status mismatch, expected %0d, actual %0d", $realtime,
               want.status, got.status);
      n_errors++;
    end
    if (got.is_empty !== want.is_empty) begin
      $display("%0t: is_empty mismatch, expected %0d, actual %0d", $realtime,
               want.is_empty, got.is_empty);
      n_errors++;
    end
    case (want.status)
      ST_FULL: n_full++;
      ST_EMPTY: n_empty++;
      default: begin
        if (want.operation == OP_PUSH) n_push_ok++;
        else if (want.operation == OP_POP) n_pop_ok++;
        else if (want.operation == OP_PEEK) n_peek_ok++;
      end
    endcase
  endtask

  // Request driver: holds a beat until taken, then an optional gap
  always @(negedge clk) begin : drive_requests
    queue_op_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req_beat) begin
      // beat still on offer
    end else if (send_gap > 0) begin
      req.valid <= 1'b0;
      send_gap--;
    end else if (op_backlog.size() > 0) begin
      nxt = op_backlog.pop_front();
      req.valid <= 1'b1;
      req.operation <= nxt.operation;
      req.item_value <= nxt.value;
      req.item_priority <= nxt.prio;
      if (send_calm > 0) begin
        send_calm--;
        send_gap = 0;
      end else begin
        if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
        send_gap = random_gap();
      end
    end else begin
      req.valid <= 1'b0;
    end
  end

  // Response ready: random stalls, calm stretches and one long hold-off
  always @(negedge clk) begin : drive_ready
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
      if (recv_calm > 0) begin
        recv_calm--;
      end else if ($urandom_range(0, 49) == 0) begin
        recv_calm = $urandom_range(20, 80);
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = random_gap();
      end
    end
  end

  // Beat monitor: prediction, checking and the stall watchdog
  always @(posedge clk) begin : observe
    queue_op_t    op;
    head_result_t got;
    logic         rsp_beat;
    logic         cfg_beat;
    if (rst) begin
      req_beat = 1'b0;
      idle_cycles = 0;
    end else begin
      req_beat = req.valid && req.ready;
      rsp_beat = rsp.valid && rsp.ready;
      cfg_beat = cfg.valid && cfg.ready;
      if (cfg_beat) begin
        largest_first = cfg.order_mode;
        n_mode_writes++;
      end
      if (req_beat) begin
        op.operation = req.operation;
        op.value = req.item_value;
        op.prio = req.item_priority;
        expected_heads.push_back(apply_queue_op(op));
        n_taken++;
      end
      if (rsp_beat) begin
        got.operation = OP_NOP;
        got.value = rsp.head_value;
        got.prio = rsp.head_priority;
        got.status = rsp.status;
        got.is_empty = rsp.is_empty;
        if (expected_heads.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %0d priority %0d",
                   $realtime, got.value, got.prio);
          n_errors++;
        end else begin
          check_head(expected_heads.pop_front(), got);
        end
        n_checked++;
      end
      if (req_beat || rsp_beat || cfg_beat) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding", $realtime,
                 idle_cycles, expected_heads.size());
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Stimulus and phase sequencing
  initial begin : run
    int ph;
    int target;
    rst = 1'b1;
    req.valid = 1'b0;
    req.operation = OP_PUSH;
    req.item_value = '0;
    req.item_priority = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.order_mode = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < PHASES; ph++) begin
      write_order_mode(MODE_PLAN[ph]);
      if (ph == 2) hold_request = 1'b1;
      target = n_meaningful + PHASE_ITEMS;
      if (ph == 0) begin
        directed_ops();
        fill_then_drain();
      end
      while (n_meaningful < target) begin
        case ($urandom_range(0, 9))
          0, 1: fill_then_drain();
          2, 3: tie_burst();
          default: random_run(20);
        endcase
      end
      // leave entries behind so the next ordering meets a populated store
      repeat ($urandom_range(2, 6)) add_op(OP_PUSH, pick_value(), pick_prio());
      wait_quiet();
    end

    if (expected_heads.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, expected_heads.size());
      n_errors++;
    end
    $display("Covered %0d requests over %0d mode writes: %0d pushes, %0d pops, %0d peeks",
             n_checked, n_mode_writes, n_push_ok, n_pop_ok, n_peek_ok);
    $display("Dropped on full: %0d, empty reads: %0d, mismatches: %0d",
             n_full, n_empty, n_errors);
    if (n_errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
